@@ rtl/dfw_pkg.sv @@
// Shared types and codes for the deduplicating FIFO worklist.
package dfw_pkg;

	localparam int unsigned ITEM_W = 8;
	localparam int unsigned CAP_W  = 9;
	localparam int unsigned OCC_W  = 9;

	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_POP   = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_DONE   = 3'd0,
		ST_QUEUED = 3'd1,
		ST_RANGE  = 3'd2,
		ST_FULL   = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	typedef struct packed {
		action_t             action;
		logic [ITEM_W-1:0]   item_value;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [ITEM_W-1:0]   popped_item;
		logic [OCC_W-1:0]    occupancy;
	} rsp_t;

endpackage

@@ rtl/dfw_if.sv @@
// Valid/ready stream interfaces for worklist requests and responses.
interface dfw_req_if;
	import dfw_pkg::*;

	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface dfw_rsp_if;
	import dfw_pkg::*;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/dfw_ring.sv @@
// Ring storage for queued indices: one write port, registered read with write bypass.
module dfw_ring #(
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned DATA_W = 8
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [DATA_W-1:0]          wr_data,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [DATA_W-1:0]          rd_data
);
	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// A write landing on the slot being read returns the new value
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

@@ rtl/dedup_fifo_worklist.sv @@
// Deduplicating FIFO worklist: a ring of item indices in arrival order plus a
// presence bitmap, so any index is queued at most once. Each request (push,
// pop, clear) gives exactly one response with a status, the popped index
// (zero unless a pop succeeded) and the occupancy after the operation. The
// block takes one request per clock and keeps that rate as long as the
// response side keeps taking; a request is captured in an input register and
// its response is then loaded into the output register, which holds it until
// the response side takes it. The ring has one write port and a separate
// registered read port: the head entry is always prefetched into a read
// register, so a pop needs no extra memory access. A write of the capacity
// register (clamped to 1..MAX_CAPACITY, zero acts as 1) also empties
// the queue and the bitmap; write it only while no request is in flight.
// Reset clears the pointers and the bitmap at once; no sweep is needed.
module dedup_fifo_worklist #(
	parameter int unsigned MAX_CAPACITY = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	dfw_req_if.sink                 req,
	dfw_rsp_if.source               rsp,
	input  logic                    cfg_wr_en,
	input  logic [dfw_pkg::CAP_W-1:0] cfg_wr_data
);
	import dfw_pkg::*;

	localparam int unsigned PTR_W  = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
	localparam int unsigned PRES_N = (MAX_CAPACITY < 256) ? MAX_CAPACITY : 256;
	localparam int unsigned PRES_W = (PRES_N > 1) ? $clog2(PRES_N) : 1;
	localparam int unsigned SUM_W  = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
	localparam logic [16:0] MAX_CAP_W = 17'(MAX_CAPACITY);

	// Configuration and queue state
	logic [CAP_W-1:0]   cap_reg_q;
	logic [PTR_W-1:0]   head_q;
	logic [CAP_W-1:0]   count_q;
	logic [PRES_N-1:0]  presence_q;

	// Input stage
	logic               valid_s1;
	action_t            action_s1;
	logic [ITEM_W-1:0]  item_s1;

	// Output register
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               advance;
	logic [CAP_W-1:0]   cap;
	logic [ITEM_W-1:0]  head_data;

	// Per-operation results
	status_t            status_d;
	logic [ITEM_W-1:0]  popped_d;
	logic [PTR_W-1:0]   head_d;
	logic [CAP_W-1:0]   count_d;
	logic               pres_set;
	logic               pres_clr;
	logic               wipe;
	logic               ring_we;
	logic [SUM_W-1:0]   tail_sum;
	logic [SUM_W-1:0]   head_inc;
	logic [PTR_W-1:0]   tail_addr;

	// Advance the input stage when the output register is free or draining
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Clamp the capacity register into 1..MAX_CAPACITY
	always_comb begin
		if (cap_reg_q == '0) begin
			cap = CAP_W'(1);
		end else if (17'(cap_reg_q) > MAX_CAP_W) begin
			cap = CAP_W'(MAX_CAPACITY);
		end else begin
			cap = cap_reg_q;
		end
	end

	// Tail slot and next head, both wrapped at the capacity in use
	always_comb begin
		tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
		if (tail_sum >= SUM_W'(cap)) begin
			tail_sum = tail_sum - SUM_W'(cap);
		end
		tail_addr = tail_sum[PTR_W-1:0];

		head_inc = SUM_W'(head_q) + SUM_W'(1);
		if (head_inc >= SUM_W'(cap)) begin
			head_inc = '0;
		end
	end

	// Operation decode; state only moves when the staged request advances
	always_comb begin
		status_d = ST_DONE;
		popped_d = '0;
		head_d   = head_q;
		count_d  = count_q;
		pres_set = 1'b0;
		pres_clr = 1'b0;
		wipe     = 1'b0;
		ring_we  = 1'b0;
		unique case (action_s1)
			ACT_PUSH: begin
				if (CAP_W'(item_s1) >= cap) begin
					status_d = ST_RANGE;
				end else if (presence_q[item_s1[PRES_W-1:0]]) begin
					status_d = ST_QUEUED;
				end else if (count_q >= cap) begin
					status_d = ST_FULL;
				end else begin
					ring_we  = advance;
					pres_set = advance;
					count_d  = count_q + CAP_W'(1);
				end
			end
			ACT_POP: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					popped_d = head_data;
					pres_clr = advance;
					head_d   = head_inc[PTR_W-1:0];
					count_d  = count_q - CAP_W'(1);
				end
			end
			ACT_CLEAR: begin
				wipe    = advance;
				head_d  = '0;
				count_d = '0;
			end
			default: begin
				// Unused code: no change, report done
			end
		endcase
	end

	// Ring with the head entry prefetched for the next request
	logic [PTR_W-1:0] rd_addr;

	always_comb begin
		if (cfg_wr_en) begin
			rd_addr = '0;
		end else if (advance) begin
			rd_addr = head_d;
		end else begin
			rd_addr = head_q;
		end
	end

	dfw_ring #(
		.DEPTH  (MAX_CAPACITY),
		.DATA_W (ITEM_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (ring_we),
		.wr_addr (tail_addr),
		.wr_data (item_s1),
		.rd_addr (rd_addr),
		.rd_data (head_data)
	);

	// Input stage: hold while stalled, load on each request transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (req.valid && req.ready) || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.payload.action;
			item_s1   <= req.payload.item_value;
		end
	end

	// Queue state; a capacity write restarts an empty queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_reg_q <= CAP_RESET;
			head_q    <= '0;
			count_q   <= '0;
		end else if (cfg_wr_en) begin
			cap_reg_q <= cfg_wr_data;
			head_q    <= '0;
			count_q   <= '0;
		end else if (advance) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// Presence bitmap: set on push, drop on pop, wipe on clear or reconfigure
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presence_q <= '0;
		end else if (cfg_wr_en || wipe) begin
			presence_q <= '0;
		end else begin
			if (pres_set) begin
				presence_q[item_s1[PRES_W-1:0]] <= 1'b1;
			end
			if (pres_clr) begin
				presence_q[head_data[PRES_W-1:0]] <= 1'b0;
			end
		end
	end

	// Output register: load on advance, drop after the response transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.status      <= status_d;
			rsp_q.popped_item <= popped_d;
			rsp_q.occupancy   <= OCC_W'(count_d);
		end
	end
endmodule

@@ test/dfw_checker.sv @@
// Checker for the deduplicating FIFO worklist: predicts each response and compares it.
`timescale 1ns / 1ps

module dfw_checker #(
	parameter int unsigned MAX_CAPACITY = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	dfw_req_if                        req,
	dfw_rsp_if                        rsp,
	input  logic                      cfg_wr_en,
	input  logic [dfw_pkg::CAP_W-1:0] cfg_wr_data,
	output int                        fail_count,
	output int                        outstanding
);
	import dfw_pkg::*;

	logic [ITEM_W-1:0] ring_slots [MAX_CAPACITY];
	logic              queued_flag [MAX_CAPACITY];
	int unsigned       head_idx;
	int unsigned       queued_count;
	logic [CAP_W-1:0]  capacity_reg;
	rsp_t              expected_rsp_q [$];
	int                mismatches;

	assign fail_count = mismatches;

	function automatic void drop_all_entries();
		head_idx     = 0;
		queued_count = 0;
		queued_flag  = '{default: 1'b0};
	endfunction

	// Apply one request to the shadow worklist and return the response it earns.
	function automatic rsp_t predict_response(input req_t r);
		rsp_t        e;
		int unsigned cap;
		int unsigned slot;
		int unsigned popped;
		cap = 32'(capacity_reg);
		if (cap < 1)
			cap = 1;
		if (cap > MAX_CAPACITY)
			cap = MAX_CAPACITY;
		e.status      = ST_DONE;
		e.popped_item = '0;
		case (r.action)
			ACT_PUSH: begin
				if (r.item_value >= cap) begin
					e.status = ST_RANGE;
				end else if (queued_flag[r.item_value]) begin
					e.status = ST_QUEUED;
				end else if (queued_count >= cap) begin
					e.status = ST_FULL;
				end else begin
					slot = head_idx + queued_count;
					if (slot >= cap)
						slot -= cap;
					ring_slots[slot]         = r.item_value;
					queued_flag[r.item_value] = 1'b1;
					queued_count++;
				end
			end
			ACT_POP: begin
				if (queued_count == 0) begin
					e.status = ST_EMPTY;
				end else begin
					popped        = 32'(ring_slots[head_idx]);
					e.popped_item = popped[ITEM_W-1:0];
					head_idx++;
					if (head_idx >= cap)
						head_idx = 0;
					queued_count--;
					queued_flag[popped] = 1'b0;
				end
			end
			ACT_CLEAR: begin
				drop_all_entries();
			end
			default: begin
			end
		endcase
		e.occupancy = queued_count[OCC_W-1:0];
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			capacity_reg = CAP_RESET;
			ring_slots   = '{default: '0};
			drop_all_entries();
			expected_rsp_q.delete();
			mismatches   = 0;
			outstanding <= 0;
		end else begin
			// The response taken at this edge belongs to an earlier request.
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp_q.size() == 0) begin
					mismatches++;
					$display("%0t: response with none expected: status %0d popped %0d occupancy %0d",
						$time, rsp.payload.status, rsp.payload.popped_item,
						rsp.payload.occupancy);
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.payload.status !== want.status) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.payload.status);
					end
					if (rsp.payload.popped_item !== want.popped_item) begin
						mismatches++;
						$display("%0t: popped_item expected %0d actual %0d",
							$time, want.popped_item, rsp.payload.popped_item);
					end
					if (rsp.payload.occupancy !== want.occupancy) begin
						mismatches++;
						$display("%0t: occupancy expected %0d actual %0d",
							$time, want.occupancy, rsp.payload.occupancy);
					end
				end
			end
			if (req.valid && req.ready)
				expected_rsp_q.push_back(predict_response(req.payload));
			if (cfg_wr_en) begin
				capacity_reg = cfg_wr_data;
				drop_all_entries();
			end
			outstanding <= expected_rsp_q.size();
		end
	end

endmodule

@@ test/tb_dedup_fifo_worklist.sv @@
// Testbench top for the deduplicating FIFO worklist: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_dedup_fifo_worklist;
	import dfw_pkg::*;

	localparam int unsigned MAX_CAP     = 256;
	localparam int          CYCLE_LIMIT = 100000;
	localparam int          LONG_HOLD   = 200;
	localparam int          SEG_ITEMS   = 100;
	localparam int          SEG_COUNT   = 6;
	// Action code the block must treat as a no-op.
	localparam action_t     ACT_UNUSED  = action_t'(2'd3);

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CAP_W-1:0] cfg_wr_data;
	int               fail_count;
	int               outstanding;
	int               cycle_count;

	// Idle odds in percent, changed by the main sequence per phase.
	int  send_idle;
	int  recv_idle;
	// Set by the main sequence to ask the receiver for one long hold-off.
	bit  hold_request;
	int  stall_left;

	dfw_req_if req_ch ();
	dfw_rsp_if rsp_ch ();

	dedup_fifo_worklist #(
		.MAX_CAPACITY(MAX_CAP)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	dfw_checker #(
		.MAX_CAPACITY(MAX_CAP)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: a hung handshake or a missing response ends up here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_dedup_fifo_worklist NOT OK");
		$finish;
	end

	// Response side: random stalls, plus one long hold-off on request so the
	// block backs up and has to stall its input.
	initial begin
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = LONG_HOLD - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Offer one request, idling first at random, and return at the edge of its transfer.
	// Valid stays high on return so back-to-back requests need no extra assignment.
	task automatic send_request(input action_t act, input logic [ITEM_W-1:0] value);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.payload.action <= act;
		req_ch.payload.item_value <= value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Drop valid, let every response drain, then write the capacity register.
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Random request: mostly pushes of in-range indices and pops, so the queue
	// gets deep and duplicates show up; a few wide indices, clears and no-ops.
	task automatic send_random(input int unsigned cap);
		int unsigned roll;
		logic [ITEM_W-1:0] value;
		roll  = $urandom_range(99);
		value = ITEM_W'($urandom_range(255));
		if (roll < 55) begin
			if ($urandom_range(99) < 85)
				value = ITEM_W'($urandom_range(cap - 1));
			send_request(ACT_PUSH, value);
		end else if (roll < 95) begin
			send_request(ACT_POP, value);
		end else if (roll < 98) begin
			send_request(ACT_CLEAR, value);
		end else begin
			send_request(ACT_UNUSED, value);
		end
	endtask

	initial begin
		logic [CAP_W-1:0] seg_caps [SEG_COUNT];
		int unsigned      eff_cap;
		seg_caps     = '{9'd5, 9'd511, 9'd0, 9'd256, 9'd17, 9'd3};
		send_idle    = 34;
		recv_idle    = 83;
		hold_request = 1'b0;
		arst_n       = 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_wr_data  <= '0;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity: both ends of the index range, a duplicate, pops to empty,
		// a clear, and the unused action code.
		send_request(ACT_PUSH, 8'd0);
		send_request(ACT_PUSH, 8'd255);
		send_request(ACT_PUSH, 8'd0);
		send_request(ACT_PUSH, 8'd170);
		send_request(ACT_POP, 8'd255);
		send_request(ACT_POP, 8'd0);
		send_request(ACT_POP, 8'd85);
		send_request(ACT_POP, 8'd255);
		send_request(ACT_PUSH, 8'd85);
		send_request(ACT_CLEAR, 8'd255);
		send_request(ACT_POP, 8'd0);
		send_request(ACT_UNUSED, 8'd255);
		send_request(ACT_PUSH, 8'd85);

		// Smallest capacity: only index 0 is legal.
		write_capacity(9'd1);
		send_request(ACT_PUSH, 8'd0);
		send_request(ACT_PUSH, 8'd0);
		send_request(ACT_PUSH, 8'd1);
		send_request(ACT_PUSH, 8'd255);
		send_request(ACT_POP, 8'd0);
		send_request(ACT_POP, 8'd0);

		// Capacity two: drive the tail and head pointers around the ring.
		write_capacity(9'd2);
		send_request(ACT_PUSH, 8'd1);
		send_request(ACT_PUSH, 8'd0);
		send_request(ACT_PUSH, 8'd1);
		send_request(ACT_POP, 8'd0);
		send_request(ACT_PUSH, 8'd1);
		send_request(ACT_POP, 8'd0);
		send_request(ACT_POP, 8'd0);
		send_request(ACT_POP, 8'd0);

		// Random segments, two per idling phase, each at its own capacity.
		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			write_capacity(seg_caps[seg]);
			eff_cap = 32'(seg_caps[seg]);
			if (eff_cap < 1)
				eff_cap = 1;
			if (eff_cap > MAX_CAP)
				eff_cap = MAX_CAP;
			if (seg < 2) begin
				send_idle = 34;
				recv_idle = 83;
			end else if (seg < 4) begin
				send_idle = 83;
				recv_idle = 34;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			// Back the block up once while requests keep coming.
			if (seg == 4)
				hold_request = 1'b1;
			for (int n = 0; n < SEG_ITEMS; n++)
				send_random(eff_cap);
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_dedup_fifo_worklist OK");
		else
			$display("tb_dedup_fifo_worklist NOT OK");
		$finish;
	end

endmodule
